### src/pareto_filter_table_defines.svh
// assertion macros for the pareto filter table
// used by the top level, expects clk_i and rst_ni in scope
`ifndef PARETO_FILTER_TABLE_DEFINES_SVH
`define PARETO_FILTER_TABLE_DEFINES_SVH

// property must hold on every clock edge out of reset
`define PFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked on every clock edge out of reset
`define PFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/pft_pkg.sv
// package for the pareto filter table: types, constants, register map
// no dependencies
package pft_pkg;

  localparam int FILTER_DEPTH_DEF  = 64;
  localparam int MEASURE_WIDTH_DEF = 32;
  localparam int FACTOR_W          = 32;
  localparam int CAP_W             = 7;
  localparam int OUT_COUNT_W       = 7;
  localparam int PADDR_W           = 4;
  localparam int PDATA_W           = 32;

  localparam logic [CAP_W-1:0]    CAPACITY_RST = 7'd50;
  localparam logic [FACTOR_W-1:0] BETA_RST     = 32'd4294924346;
  localparam logic [FACTOR_W-1:0] GAMMA_RST    = 32'd42950;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_BETA     = 2'd1;
  localparam logic [1:0] REG_GAMMA    = 2'd2;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_ACCEPT = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LT,
    ST_DEL,
    ST_EVICT,
    ST_BMUL,
    ST_AP,
    ST_INS,
    ST_ACC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic del_go;
    logic ins_go;
    logic ap_load;
    logic lt_load;
  } cell_ctl_t;

endpackage

### src/pft_if.sv
// item channels of the pareto filter table
// depends on nothing but the measure width parameter
interface pft_in_if #(parameter int MEASURE_WIDTH = 32);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      mode;
  logic [MEASURE_WIDTH-1:0]        infeasibility_in;
  logic signed [MEASURE_WIDTH-1:0] optimality_in;
  modport source (output valid, mode, infeasibility_in, optimality_in, input ready);
  modport sink (input valid, mode, infeasibility_in, optimality_in, output ready);
endinterface

interface pft_out_if #(parameter int MEASURE_WIDTH = 32);
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic                     filter_empty;
  logic [MEASURE_WIDTH-1:0] smallest_infeasibility;
  logic [6:0]               entry_count;
  modport source (output valid, accepted, filter_empty, smallest_infeasibility, entry_count,
                  input ready);
  modport sink (input valid, accepted, filter_empty, smallest_infeasibility, entry_count,
                output ready);
endinterface

### src/pft_cell.sv
// one filter entry: holds a pair, compares it to the incoming item
// and shifts left or right with its neighbors; uses pft_pkg
module pft_cell
  import pft_pkg::*;
#(
  parameter int MEASURE_WIDTH = MEASURE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  cell_ctl_t                       ctl_i,
  input  logic [FACTOR_W-1:0]             beta_i,
  input  logic                            valid_i,
  input  logic                            prev_lt_i,
  input  logic                            prev_ltq_i,
  input  logic                            prev_ap_i,
  input  logic                            prev_apc_i,
  input  logic [MEASURE_WIDTH-1:0]        left_h_i,
  input  logic signed [MEASURE_WIDTH-1:0] left_f_i,
  input  logic [MEASURE_WIDTH-1:0]        right_h_i,
  input  logic signed [MEASURE_WIDTH-1:0] right_f_i,
  input  logic [MEASURE_WIDTH-1:0]        new_h_i,
  input  logic signed [MEASURE_WIDTH-1:0] new_f_i,
  output logic [MEASURE_WIDTH-1:0]        h_o,
  output logic signed [MEASURE_WIDTH-1:0] f_o,
  output logic                            lt_o,
  output logic                            ltq_o,
  output logic                            ap_o,
  output logic                            apc_o,
  output logic                            del_o
);
  localparam int PW = MEASURE_WIDTH + FACTOR_W;

  logic [MEASURE_WIDTH-1:0]        h_q, h_d;
  logic signed [MEASURE_WIDTH-1:0] f_q, f_d;
  logic                            ap_q, ap_d;
  logic                            lt_q, lt_d;
  logic [PW-1:0]                   prod;
  logic                            le;

  // lt and ap are prefix flags: set only while every cell to the left is set too
  assign prod  = PW'(beta_i) * PW'(h_q);
  assign lt_d  = valid_i && (h_q < new_h_i) && prev_lt_i;
  assign le    = new_f_i <= f_q;
  assign del_o = valid_i && !lt_q && le && prev_ltq_i;
  assign ap_d  = valid_i && ({new_h_i, {FACTOR_W{1'b0}}} >= prod) && prev_apc_i;

  always_comb begin
    h_d = h_q;
    f_d = f_q;
    if (ctl_i.del_go && !lt_q) begin
      h_d = right_h_i;
      f_d = right_f_i;
    end else if (ctl_i.ins_go && !ap_q) begin
      if (prev_ap_i) begin
        h_d = new_h_i;
        f_d = new_f_i;
      end else begin
        h_d = left_h_i;
        f_d = left_f_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    f_q <= f_d;
    if (ctl_i.ap_load) begin
      ap_q <= ap_d;
    end
    if (ctl_i.lt_load) begin
      lt_q <= lt_d;
    end
  end

  assign h_o   = h_q;
  assign f_o   = f_q;
  assign lt_o  = lt_d;
  assign ltq_o = lt_q;
  assign ap_o  = ap_q;
  assign apc_o = ap_d;
endmodule

### src/pareto_filter_table.sv
// Add: load compare flags, remove dominated entries, evict the last entry when full
// (rescaling a finite bound), load insert flags, insert; accept: load the flags,
// decide; clear and unused mode: straight to the result. One item at a time; idle
// (ready) starts as the result register loads, which lets it in while it waits.
// Reset (async, active low) empties the filter, makes the bound infinite and loads
// the register defaults; entry contents are undefined until written.
`include "pareto_filter_table_defines.svh"
module pareto_filter_table
  import pft_pkg::*;
#(
  parameter int FILTER_DEPTH  = FILTER_DEPTH_DEF,
  parameter int MEASURE_WIDTH = MEASURE_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pft_in_if.sink              in_i,
  pft_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);
  localparam int W     = MEASURE_WIDTH;
  localparam int PW    = W + FACTOR_W;
  localparam int CNT_W = $clog2(FILTER_DEPTH + 1);
  localparam int IDX_W = $clog2(FILTER_DEPTH);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]    cap_q;
  logic [FACTOR_W-1:0] beta_q, gamma_q;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [W-1:0]      bound_q, bound_d;
  logic              bound_inf_q, bound_inf_d;
  logic [1:0]        mode_q;
  logic [W-1:0]      h_q;
  logic signed [W-1:0] f_q;
  logic [W-1:0]      m_q, m_d;
  logic              rej_q;
  logic [PW-1:0]     gh_q;
  logic              acc_q, acc_d;
  logic              out_vld_q;
  logic              accepted_q, empty_q;
  logic [W-1:0]      smallest_q;
  logic [OUT_COUNT_W-1:0] count_out_q;
  logic              fin_go;

  cell_ctl_t         ctl;
  logic [W-1:0]        h_arr [FILTER_DEPTH];
  logic signed [W-1:0] f_arr [FILTER_DEPTH];
  logic [FILTER_DEPTH-1:0] lt_v, ltq_v, ap_v, apc_v, del_v, valid_v;

  logic [CW-1:0]     cap_ext, eff_cap;
  logic [IDX_W-1:0]  last_idx;
  logic [W-1:0]      last_h;
  logic signed [W-1:0] f_sel;
  logic signed [W:0] d_f;
  logic [PW-1:0]     bound_prod, m_prod, gh_prod;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAPACITY_RST;
      beta_q  <= BETA_RST;
      gamma_q <= GAMMA_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CAPACITY: cap_q   <= pwdata[CAP_W-1:0];
        REG_BETA:     beta_q  <= pwdata;
        REG_GAMMA:    gamma_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CAPACITY: prdata = PDATA_W'(cap_q);
      REG_BETA:     prdata = beta_q;
      REG_GAMMA:    prdata = gamma_q;
      default:      prdata = '0;
    endcase
  end

  // cell chain
  for (genvar i = 0; i < FILTER_DEPTH; i++) begin : g_cell
    logic            prev_lt, prev_ltq, prev_ap, prev_apc;
    logic [W-1:0]    lh, rh;
    logic signed [W-1:0] lf, rf;
    assign valid_v[i] = CNT_W'(i) < count_q;
    if (i == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_ltq = 1'b1;
      assign prev_ap  = 1'b1;
      assign prev_apc = 1'b1;
      assign lh = '0;
      assign lf = '0;
    end else begin : g_mid
      assign prev_lt  = lt_v[i-1];
      assign prev_ltq = ltq_v[i-1];
      assign prev_ap  = ap_v[i-1];
      assign prev_apc = apc_v[i-1];
      assign lh = h_arr[i-1];
      assign lf = f_arr[i-1];
    end
    if (i == FILTER_DEPTH - 1) begin : g_last
      assign rh = '0;
      assign rf = '0;
    end else begin : g_inner
      assign rh = h_arr[i+1];
      assign rf = f_arr[i+1];
    end
    pft_cell #(.MEASURE_WIDTH(W)) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .beta_i     (beta_q),
      .valid_i    (valid_v[i]),
      .prev_lt_i  (prev_lt),
      .prev_ltq_i (prev_ltq),
      .prev_ap_i  (prev_ap),
      .prev_apc_i (prev_apc),
      .left_h_i   (lh),
      .left_f_i   (lf),
      .right_h_i  (rh),
      .right_f_i  (rf),
      .new_h_i    (h_q),
      .new_f_i    (f_q),
      .h_o        (h_arr[i]),
      .f_o        (f_arr[i]),
      .lt_o       (lt_v[i]),
      .ltq_o      (ltq_v[i]),
      .ap_o       (ap_v[i]),
      .apc_o      (apc_v[i]),
      .del_o      (del_v[i])
    );
  end

  assign cap_ext = CW'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(FILTER_DEPTH)) begin
      eff_cap = CW'(FILTER_DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign last_h   = h_arr[last_idx];

  // optimality of the entry just before the insert position
  always_comb begin
    f_sel = '0;
    for (int i = 0; i < FILTER_DEPTH; i++) begin
      if (ap_v[i] && (i == FILTER_DEPTH - 1 || !ap_v[(i + 1) % FILTER_DEPTH])) begin
        f_sel = f_sel | f_arr[i];
      end
    end
  end

  assign d_f        = {f_sel[W-1], f_sel} - {f_q[W-1], f_q};
  assign bound_prod = PW'(beta_q) * PW'(bound_q);
  assign m_prod     = PW'(beta_q) * PW'(m_q);
  assign gh_prod    = PW'(gamma_q) * PW'(h_q);
  assign fin_go     = !out_vld_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    bound_d     = bound_q;
    bound_inf_d = bound_inf_q;
    m_d         = m_q;
    acc_d       = acc_q;
    ctl         = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          acc_d = 1'b0;
          priority case (in_i.mode)
            MODE_ADD:    state_d = ST_LT;
            MODE_ACCEPT: state_d = ST_AP;
            MODE_CLEAR: begin
              count_d     = '0;
              bound_inf_d = 1'b1;
              bound_d     = '0;
              state_d     = ST_FIN;
            end
            default:     state_d = ST_FIN;
          endcase
        end
      end
      ST_LT: begin
        ctl.lt_load = 1'b1;
        state_d     = ST_DEL;
      end
      ST_DEL: begin
        if (|del_v) begin
          ctl.del_go = 1'b1;
          count_d    = count_q - CNT_W'(1);
        end else if (CW'(count_q) >= eff_cap) begin
          state_d = ST_EVICT;
        end else begin
          state_d = ST_AP;
        end
      end
      ST_EVICT: begin
        m_d     = (bound_q > last_h) ? bound_q : last_h;
        count_d = count_q - CNT_W'(1);
        state_d = bound_inf_q ? ST_AP : ST_BMUL;
      end
      ST_BMUL: begin
        bound_d = m_prod[PW-1:FACTOR_W];
        state_d = ST_AP;
      end
      ST_AP: begin
        ctl.ap_load = 1'b1;
        state_d     = (mode_q == MODE_ADD) ? ST_INS : ST_ACC;
      end
      ST_INS: begin
        ctl.ins_go = 1'b1;
        count_d    = count_q + CNT_W'(1);
        state_d    = ST_FIN;
      end
      ST_ACC: begin
        if (rej_q) begin
          acc_d = 1'b0;
        end else if (!ap_v[0]) begin
          acc_d = 1'b1;
        end else begin
          acc_d = !d_f[W] && ({1'b0, gh_q} <= {d_f, {FACTOR_W{1'b0}}});
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      bound_q     <= '0;
      bound_inf_q <= 1'b1;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bound_q     <= bound_d;
      bound_inf_q <= bound_inf_d;
      if (state_q == ST_FIN && fin_go) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    acc_q <= acc_d;
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      h_q    <= in_i.infeasibility_in;
      f_q    <= in_i.optimality_in;
    end
    if (state_q == ST_AP) begin
      rej_q <= !bound_inf_q && (bound_prod <= {h_q, {FACTOR_W{1'b0}}});
      gh_q  <= gh_prod;
    end
    if (state_q == ST_FIN && fin_go) begin
      accepted_q  <= acc_q;
      empty_q     <= (count_q == '0);
      smallest_q  <= (count_q == '0) ? '0 : h_arr[0];
      count_out_q <= OUT_COUNT_W'(count_q);
    end
  end

  assign out_o.valid                  = out_vld_q;
  assign out_o.accepted               = accepted_q;
  assign out_o.filter_empty           = empty_q;
  assign out_o.smallest_infeasibility = smallest_q;
  assign out_o.entry_count            = count_out_q;

  `PFT_ASSERT(a_count_range, count_q <= CNT_W'(FILTER_DEPTH), "entry count beyond depth")
  `PFT_ASSERT_IMP(a_busy_after_accept, in_i.valid && in_i.ready, ##1 !in_i.ready, "took two items")
  `PFT_ASSERT_IMP(a_clear_bound, state_q == ST_FIN && mode_q == MODE_CLEAR, bound_inf_q && count_q == '0, "clear left entries")
endmodule
